FILE: rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

FILE: rtl/lzbf_pkg.sv
// ----------------------------------------------------------------------------
// lzbf_pkg
// Types, constants and helpers shared by the LZ bit-flag decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzbf_pkg;

   localparam int WINDOW_DEPTH     = 8192;
   localparam int PTR_W            = $clog2(WINDOW_DEPTH);
   localparam int OFFSET_W         = 14;
   localparam int LENGTH_W         = 9;
   localparam int BYTES_PER_RESULT = 8;
   localparam int COUNT_W          = 4;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

   // Offset bases of the long-match prefix code and length biases.
   localparam logic [OFFSET_W-1:0] OFS_BASE_A   = 14'd1;
   localparam logic [OFFSET_W-1:0] OFS_BASE_B   = 14'd513;
   localparam logic [OFFSET_W-1:0] OFS_BASE_C   = 14'd1025;
   localparam logic [OFFSET_W-1:0] OFS_BASE_D   = 14'd2049;
   localparam logic [OFFSET_W-1:0] OFS_BASE_E   = 14'd4097;
   localparam logic [OFFSET_W-1:0] OFS_SHORT    = 14'd256;
   localparam logic [LENGTH_W-1:0] LEN_BYTE_ADD = 9'd17;
   localparam logic [LENGTH_W-1:0] LEN_BITS_ADD = 9'd9;
   localparam logic [LENGTH_W-1:0] LEN_SHORT    = 9'd2;
   localparam logic [7:0]          END_BYTE     = 8'hff;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       new_stream;
   } req_type;

   typedef struct packed {
      logic [63:0]        out_bytes;
      logic [COUNT_W-1:0] byte_count;
      logic               stream_end;
      logic               last_result;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_START, ST_LIT, ST_KIND, ST_LTMP0, ST_LA, ST_LB, ST_LC, ST_LD, ST_LE,
      ST_LF, ST_LG, ST_LOFFB, ST_N0, ST_N1, ST_N2, ST_N3, ST_N4, ST_N78,
      ST_N5, ST_NBYTE, ST_NB2, ST_NB1, ST_NB0, ST_SHORT, ST_S2, ST_S1, ST_S0,
      ST_SBYTE, ST_SNEAR
   } step_type;

   typedef enum logic [1:0] {
      CMD_LIT, CMD_COPY, CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [7:0]          lit;
      logic [OFFSET_W-1:0] offset;
      logic [LENGTH_W-1:0] length;
      logic                restart;
   } cmd_type;

   // Command channel from the decoder into the queue.
   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } cmd_push_type;

   typedef enum logic [2:0] {
      B_IDLE, B_READ, B_WRITE, B_ENDS
   } back_state_type;

   // True in the decode steps that consume a data byte.
   function automatic logic needs_data(input step_type s);
      return (s == ST_LIT) || (s == ST_LOFFB) || (s == ST_NBYTE) ||
             (s == ST_SBYTE) || (s == ST_SNEAR);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/lzbf_front.sv
// ----------------------------------------------------------------------------
// lzbf_front
// Token decoder: takes stream bytes, walks flag bits one per cycle while the
// command queue is not full, and issues literal, copy and end commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lzbf_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  lzbf_pkg::req_type     req_data,
   input  wire                   q_full,
   output lzbf_pkg::cmd_push_type cmd_out
);
   import lzbf_pkg::*;

   step_type            step_ff, step_in;
   logic [15:0]         flag_ff, flag_in;
   logic [4:0]          bits_ff, bits_in;
   logic [7:0]          low_ff, low_in;
   logic                lowv_ff, lowv_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic [3:0]          ohb_ff, ohb_in;
   logic [LENGTH_W-1:0] len_ff, len_in;
   logic                done_ff, done_in;
   logic                restart_ff, restart_in;

   logic     need_in, accept, bit_go, clr, f;
   logic [7:0] b;
   step_type e_step;
   logic     e_done, e_restart;
   logic [LENGTH_W-1:0] cmd_len;

   // Input is wanted when the decoder waits for a data or flag byte, or once it has seen the end marker.
   assign need_in   = done_ff || needs_data(step_ff) || (bits_ff == 5'd0);
   assign req_ready = need_in && !q_full;
   assign accept    = req_valid && req_ready;
   assign bit_go    = !need_in && !q_full;
   assign clr       = accept && req_data.new_stream;
   assign b         = req_data.in_byte;
   assign f         = flag_ff[0];

   // Decode one byte or one flag bit.
   always_comb begin
      e_step     = clr ? ST_START : step_ff;
      e_done     = clr ? 1'b0 : done_ff;
      e_restart  = restart_ff || clr;
      step_in    = e_step;
      flag_in    = clr ? 16'd0 : flag_ff;
      bits_in    = clr ? 5'd0 : bits_ff;
      low_in     = clr ? 8'd0 : low_ff;
      lowv_in    = clr ? 1'b0 : lowv_ff;
      off_in     = clr ? '0 : off_ff;
      ohb_in     = clr ? 4'd0 : ohb_ff;
      len_in     = clr ? '0 : len_ff;
      done_in    = e_done;
      restart_in = e_restart;
      cmd_out.push        = 1'b0;
      cmd_out.cmd.kind    = CMD_COPY;
      cmd_out.cmd.lit     = b;
      cmd_out.cmd.offset  = off_ff;
      cmd_out.cmd.restart = e_restart;
      cmd_len             = len_ff;
      priority if (accept && !e_done && needs_data(e_step)) begin
         unique case (e_step)
            ST_LIT: begin
               cmd_out.push     = 1'b1;
               cmd_out.cmd.kind = CMD_LIT;
               step_in          = ST_START;
            end
            ST_LOFFB: begin
               off_in  = off_in + {2'b00, ohb_in, b};
               step_in = ST_N0;
            end
            ST_NBYTE: begin
               cmd_len      = {1'b0, b} + LEN_BYTE_ADD;
               cmd_out.push = 1'b1;
               step_in      = ST_START;
            end
            ST_SBYTE: begin
               off_in       = (off_ff | {6'd0, b} | {2'b00, ohb_ff, 8'd0}) + OFS_SHORT;
               cmd_len      = LEN_SHORT;
               cmd_out.push = 1'b1;
               step_in      = ST_START;
            end
            default: begin
               off_in       = {6'd0, b} + 14'd1;
               cmd_out.push = 1'b1;
               step_in      = ST_START;
               if (b == END_BYTE) begin
                  cmd_out.cmd.kind = CMD_END;
                  done_in          = 1'b1;
               end else begin
                  cmd_len = LEN_SHORT;
               end
            end
         endcase
      end else if (accept && !e_done) begin
         // Flag word reload, low byte first.
         if (!lowv_in) begin
            low_in  = b;
            lowv_in = 1'b1;
         end else begin
            flag_in = {b, low_in};
            bits_in = 5'd16;
            lowv_in = 1'b0;
         end
      end else if (bit_go) begin
         flag_in = {1'b0, flag_ff[15:1]};
         bits_in = bits_ff - 5'd1;
         unique case (step_ff)
            ST_START: step_in = f ? ST_LIT : ST_KIND;
            ST_KIND: begin
               if (f) begin
                  off_in  = OFS_BASE_A;
                  step_in = ST_LTMP0;
               end else begin
                  step_in = ST_SHORT;
               end
            end
            ST_LTMP0: begin
               ohb_in  = {3'd0, f};
               step_in = ST_LA;
            end
            ST_LA: begin
               if (f) step_in = ST_LOFFB;
               else begin
                  off_in  = OFS_BASE_B;
                  step_in = ST_LB;
               end
            end
            ST_LB: begin
               if (f) step_in = ST_LOFFB;
               else begin
                  off_in  = OFS_BASE_C;
                  step_in = ST_LC;
               end
            end
            ST_LC: begin
               ohb_in  = {ohb_ff[2:0], f};
               step_in = ST_LD;
            end
            ST_LD: begin
               if (f) step_in = ST_LOFFB;
               else begin
                  off_in  = OFS_BASE_D;
                  step_in = ST_LE;
               end
            end
            ST_LE: begin
               ohb_in  = {ohb_ff[2:0], f};
               step_in = ST_LF;
            end
            ST_LF: begin
               if (f) step_in = ST_LOFFB;
               else begin
                  off_in  = OFS_BASE_E;
                  step_in = ST_LG;
               end
            end
            ST_LG: begin
               ohb_in  = {ohb_ff[2:0], f};
               step_in = ST_LOFFB;
            end
            ST_N0, ST_N1, ST_N2, ST_N3: begin
               if (f) begin
                  unique case (step_ff)
                     ST_N0:   cmd_len = 9'd3;
                     ST_N1:   cmd_len = 9'd4;
                     ST_N2:   cmd_len = 9'd5;
                     default: cmd_len = 9'd6;
                  endcase
                  len_in       = cmd_len;
                  cmd_out.push = 1'b1;
                  step_in      = ST_START;
               end else begin
                  unique case (step_ff)
                     ST_N0:   step_in = ST_N1;
                     ST_N1:   step_in = ST_N2;
                     ST_N2:   step_in = ST_N3;
                     default: step_in = ST_N4;
                  endcase
               end
            end
            ST_N4: step_in = f ? ST_N78 : ST_N5;
            ST_N78: begin
               cmd_len      = f ? 9'd8 : 9'd7;
               cmd_out.push = 1'b1;
               step_in      = ST_START;
            end
            ST_N5: step_in = f ? ST_NBYTE : ST_NB2;
            ST_NB2: begin
               len_in  = {6'd0, f, 2'b00};
               step_in = ST_NB1;
            end
            ST_NB1: begin
               len_in  = len_ff | {7'd0, f, 1'b0};
               step_in = ST_NB0;
            end
            ST_NB0: begin
               cmd_len      = (len_ff | {8'd0, f}) + LEN_BITS_ADD;
               cmd_out.push = 1'b1;
               step_in      = ST_START;
            end
            ST_SHORT: step_in = f ? ST_S2 : ST_SNEAR;
            ST_S2: begin
               off_in  = {3'd0, f, 10'd0};
               step_in = ST_S1;
            end
            ST_S1: begin
               off_in  = off_ff | {4'd0, f, 9'd0};
               step_in = ST_S0;
            end
            ST_S0: begin
               ohb_in  = {3'd0, f};
               step_in = ST_SBYTE;
            end
            default: step_in = ST_START;
         endcase
      end else begin
         // No transfer and no flag bit this cycle, so the decoder holds.
      end
      if (cmd_out.push) begin
         len_in     = cmd_len;
         restart_in = 1'b0;
      end
      cmd_out.cmd.offset = off_in;
      cmd_out.cmd.length = cmd_len;
   end

   // Decoder state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= ST_START;
         flag_ff    <= 16'd0;
         bits_ff    <= 5'd0;
         low_ff     <= 8'd0;
         lowv_ff    <= 1'b0;
         off_ff     <= '0;
         ohb_ff     <= 4'd0;
         len_ff     <= '0;
         done_ff    <= 1'b0;
         restart_ff <= 1'b0;
      end else begin
         step_ff    <= step_in;
         flag_ff    <= flag_in;
         bits_ff    <= bits_in;
         low_ff     <= low_in;
         lowv_ff    <= lowv_in;
         off_ff     <= off_in;
         ohb_ff     <= ohb_in;
         len_ff     <= len_in;
         done_ff    <= done_in;
         restart_ff <= restart_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/lzbf_queue.sv
// ----------------------------------------------------------------------------
// lzbf_queue
// Small command FIFO between the decoder and the copy engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lzbf_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  lzbf_pkg::cmd_push_type push_in,
   output logic                   full,
   output logic                   pop_valid,
   output lzbf_pkg::cmd_type      pop_cmd,
   input  wire                    pop
);
   import lzbf_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full      = (cnt_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_cmd   = slot_ff[rd_ff];
   assign do_push   = push_in.push && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_in.cmd;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/lzbf_back.sv
// ----------------------------------------------------------------------------
// lzbf_back
// Copy engine: writes literals and copies into the history memory, packs
// output bytes and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzbf_back (
   input  wire                clock,
   input  wire                reset,
   input  wire                q_valid,
   input  lzbf_pkg::cmd_type  q_cmd,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output lzbf_pkg::rsp_type  rsp_data
);
   import lzbf_pkg::*;

   localparam int CNT_W = $clog2(BYTES_PER_RESULT) + 1;

   logic [7:0]           hist [WINDOW_DEPTH];
   back_state_type       state_ff, state_in;
   logic [PTR_W-1:0]     wp_ff, wp_in, off_ff, rd_addr;
   logic [LENGTH_W-1:0]  rem_ff;
   logic                 lit_ff;
   logic [7:0]           byte_ff, rd_ff, data;
   logic [63:0]          pack_ff, word;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   logic                 out_free, wr_en, emit_bytes, emit_end, last_byte;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign rd_addr    = wp_ff - off_ff;
   assign data       = lit_ff ? byte_ff : rd_ff;
   assign word       = pack_ff | ({56'd0, data} << {cnt_ff, 3'b000});
   assign last_byte  = (rem_ff == 9'd1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.kind)
                  CMD_LIT:  state_in = B_WRITE;
                  CMD_COPY: state_in = B_READ;
                  default:  state_in = B_ENDS;
               endcase
            end
         end
         B_READ:  state_in = B_WRITE;
         B_WRITE: if (out_free) state_in = last_byte ? B_IDLE : B_READ;
         default: if (out_free) state_in = B_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      q_pop      = (state_ff == B_IDLE) && q_valid;
      wr_en      = (state_ff == B_WRITE) && out_free;
      emit_bytes = wr_en && (last_byte || (cnt_ff == CNT_W'(BYTES_PER_RESULT - 1)));
      emit_end   = (state_ff == B_ENDS) && out_free;
      wp_in      = wp_ff;
      if (q_pop && q_cmd.restart) begin
         wp_in = '0;
      end else if (wr_en) begin
         wp_in = wp_ff + 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         if (emit_bytes) begin
            cnt_ff <= '0;
         end else if (wr_en) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (emit_bytes || emit_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Command, packing and result payload registers.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         lit_ff  <= (q_cmd.kind == CMD_LIT);
         byte_ff <= q_cmd.lit;
         off_ff  <= q_cmd.offset[PTR_W-1:0];
         rem_ff  <= (q_cmd.kind == CMD_LIT) ? 9'd1 : q_cmd.length;
      end else if (wr_en) begin
         rem_ff <= rem_ff - 9'd1;
      end
      if (reset || emit_bytes) begin
         pack_ff <= 64'd0;
      end else if (wr_en) begin
         pack_ff <= word;
      end
      if (emit_bytes) begin
         rsp_ff.out_bytes   <= word;
         rsp_ff.byte_count  <= COUNT_W'(cnt_ff) + 4'd1;
         rsp_ff.stream_end  <= 1'b0;
         rsp_ff.last_result <= last_byte;
      end else if (emit_end) begin
         rsp_ff.out_bytes   <= 64'd0;
         rsp_ff.byte_count  <= 4'd0;
         rsp_ff.stream_end  <= 1'b1;
         rsp_ff.last_result <= 1'b1;
      end
   end

   // History memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist[wp_ff] <= data;
      end
      if (state_ff == B_READ) begin
         rd_ff <= hist[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/lz_bitflag_decompressor.sv
// A streaming LZ77 decompressor with bit-flag control. Compressed bytes enter
// one per transfer; the decoder walks one flag bit or takes one accepted byte
// at a time, and a four-entry command queue lets it run ahead of the copy
// engine. The copy engine first fetches a command; a literal is then written,
// and a match reads the history and then writes and packs each output byte,
// since the read of the 8 KiB history memory ahead of each write is registered.
// Results carry up to eight bytes; the last result of a byte is flagged.
// ----------------------------------------------------------------------------
// lz_bitflag_decompressor
// Top level: decoder, command queue and copy engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lz_bitflag_decompressor (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  lzbf_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output lzbf_pkg::rsp_type  rsp_data
);
   import lzbf_pkg::*;

   cmd_push_type push;
   cmd_type      q_cmd;
   logic         q_full, q_valid, q_pop;

   lzbf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .cmd_out   (push)
   );

   lzbf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd),
      .pop       (q_pop)
   );

   lzbf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/lzbf_checker.sv
// ----------------------------------------------------------------------------
// lzbf_checker
// Port-level checks on the result channel of the decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lzbf_port_checks (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input lzbf_pkg::rsp_type rsp_data
);
   import lzbf_pkg::*;

   logic rsp_stall, rsp_end_valid, rsp_data_valid, rsp_partial, count_ok, end_ok;

   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign rsp_end_valid  = rsp_valid && rsp_data.stream_end;
   assign rsp_data_valid = rsp_valid && !rsp_data.stream_end;
   assign rsp_partial    = rsp_data_valid && (rsp_data.byte_count != 4'(BYTES_PER_RESULT));
   assign count_ok       = (rsp_data.byte_count != 4'd0) &&
                           (rsp_data.byte_count <= 4'(BYTES_PER_RESULT));
   assign end_ok         = (rsp_data.byte_count == 4'd0) && rsp_data.last_result;

   // A stalled result holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   // The end marker carries no bytes and closes its input byte.
   `ASSERT_IMPLIES(a_end_form, clock, reset, rsp_end_valid, end_ok)
   // A data result carries between one and eight bytes.
   `ASSERT_IMPLIES(a_data_count, clock, reset, rsp_data_valid, count_ok)
   // A partly filled result is always the last one of its byte.
   `ASSERT_IMPLIES(a_partial_last, clock, reset, rsp_partial, rsp_data.last_result)

endmodule

bind lz_bitflag_decompressor lzbf_port_checks u_lzbf_port_checks (.*);

`default_nettype wire

FILE: test/lzbf_checker.sv
// ----------------------------------------------------------------------------
// lzbf_checker
// Watches both channels of the LZ bit-flag decompressor, decodes every
// accepted compressed byte with its own decoder and compares each result
// transfer with the oldest expected result.
// ----------------------------------------------------------------------------
`default_nettype none

module lzbf_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  lzbf_pkg::req_type  req_data,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  lzbf_pkg::rsp_type  rsp_data,
   output int                 fail_count,
   output int                 pending
);
   import lzbf_pkg::*;

   // Decoder state.
   logic [7:0]  hist [0:WINDOW_DEPTH-1];
   logic [12:0] wptr;
   logic [15:0] fword;
   int          fleft;
   logic [7:0]  low_byte;
   bit          low_held;
   step_type    st;
   logic [13:0] mofs;
   logic [3:0]  hibits;
   int          mlen;
   bit          ended;
   logic [7:0]  decoded [$];
   rsp_type     expected_rsp [$];

   function automatic void restart_stream();
      wptr = '0;
      fword = '0;
      fleft = 0;
      low_byte = '0;
      low_held = 0;
      st = ST_START;
      mofs = '0;
      hibits = '0;
      mlen = 0;
      ended = 0;
   endfunction

   function automatic void emit(input logic [7:0] v);
      hist[wptr] = v;
      wptr = wptr + 13'd1;
      decoded.push_back(v);
   endfunction

   // Byte-by-byte copy, so an overlapping match repeats recent output.
   function automatic void copy_match();
      logic [12:0] idx;
      for (int i = 0; i < mlen; i++) begin
         idx = wptr - mofs[12:0];
         emit(hist[idx]);
      end
      st = ST_START;
   endfunction

   function automatic void take_data(input logic [7:0] b);
      case (st)
         ST_LIT: begin
            emit(b);
            st = ST_START;
         end
         ST_LOFFB: begin
            mofs = mofs + {2'b00, hibits, b};
            st = ST_N0;
         end
         ST_NBYTE: begin
            mlen = b + 17;
            copy_match();
         end
         ST_SBYTE: begin
            mofs = (mofs | {6'd0, b} | {2'b00, hibits, 8'd0}) + 14'd256;
            mlen = 2;
            copy_match();
         end
         default: begin
            // Near short match; an offset of 256 is the end marker.
            mofs = b + 14'd1;
            if (mofs == 14'd256) begin
               ended = 1;
               st = ST_START;
            end else begin
               mlen = 2;
               copy_match();
            end
         end
      endcase
   endfunction

   function automatic void take_flag(input bit f);
      case (st)
         ST_START: st = f ? ST_LIT : ST_KIND;
         ST_KIND: begin
            if (f) begin
               mofs = 14'd1;
               st = ST_LTMP0;
            end else begin
               st = ST_SHORT;
            end
         end
         ST_LTMP0: begin
            hibits = {3'd0, f};
            st = ST_LA;
         end
         ST_LA: begin
            if (f) st = ST_LOFFB;
            else begin
               mofs = 14'd513;
               st = ST_LB;
            end
         end
         ST_LB: begin
            if (f) st = ST_LOFFB;
            else begin
               mofs = 14'd1025;
               st = ST_LC;
            end
         end
         ST_LC: begin
            hibits = {hibits[2:0], f};
            st = ST_LD;
         end
         ST_LD: begin
            if (f) st = ST_LOFFB;
            else begin
               mofs = 14'd2049;
               st = ST_LE;
            end
         end
         ST_LE: begin
            hibits = {hibits[2:0], f};
            st = ST_LF;
         end
         ST_LF: begin
            if (f) st = ST_LOFFB;
            else begin
               mofs = 14'd4097;
               st = ST_LG;
            end
         end
         ST_LG: begin
            hibits = {hibits[2:0], f};
            st = ST_LOFFB;
         end
         ST_N0: if (f) begin mlen = 3; copy_match(); end else st = ST_N1;
         ST_N1: if (f) begin mlen = 4; copy_match(); end else st = ST_N2;
         ST_N2: if (f) begin mlen = 5; copy_match(); end else st = ST_N3;
         ST_N3: if (f) begin mlen = 6; copy_match(); end else st = ST_N4;
         ST_N4: st = f ? ST_N78 : ST_N5;
         ST_N78: begin
            mlen = f ? 8 : 7;
            copy_match();
         end
         ST_N5: st = f ? ST_NBYTE : ST_NB2;
         ST_NB2: begin
            mlen = f << 2;
            st = ST_NB1;
         end
         ST_NB1: begin
            mlen = mlen | (f << 1);
            st = ST_NB0;
         end
         ST_NB0: begin
            mlen = (mlen | f) + 9;
            copy_match();
         end
         ST_SHORT: st = f ? ST_S2 : ST_SNEAR;
         ST_S2: begin
            mofs = {3'd0, f, 10'd0};
            st = ST_S1;
         end
         ST_S1: begin
            mofs = mofs | {4'd0, f, 9'd0};
            st = ST_S0;
         end
         ST_S0: begin
            hibits = {3'd0, f};
            st = ST_SBYTE;
         end
         default: st = ST_START;
      endcase
   endfunction

   // Decodes one compressed byte and queues the results it produces.
   function automatic void decode_byte(input req_type rq);
      bit      avail;
      int      nres;
      rsp_type r;
      avail = 1;
      if (rq.new_stream) restart_stream();
      if (ended) return;
      decoded.delete();
      while (!ended) begin
         if (st inside {ST_LIT, ST_LOFFB, ST_NBYTE, ST_SBYTE, ST_SNEAR}) begin
            if (!avail) break;
            avail = 0;
            take_data(rq.in_byte);
         end else if (fleft == 0) begin
            // Flag word reload, low byte first.
            if (!avail) break;
            avail = 0;
            if (!low_held) begin
               low_byte = rq.in_byte;
               low_held = 1;
            end else begin
               fword = {rq.in_byte, low_byte};
               fleft = 16;
               low_held = 0;
            end
         end else begin
            take_flag(fword[0]);
            fword = fword >> 1;
            fleft--;
         end
      end
      nres = (decoded.size() + BYTES_PER_RESULT - 1) / BYTES_PER_RESULT;
      for (int k = 0; k < nres; k++) begin
         r = '0;
         for (int i = 0; i < BYTES_PER_RESULT; i++) begin
            if (k * BYTES_PER_RESULT + i < decoded.size()) begin
               r.out_bytes[8*i +: 8] = decoded[k * BYTES_PER_RESULT + i];
               r.byte_count = r.byte_count + 1'b1;
            end
         end
         r.last_result = (k + 1 == nres) && !ended;
         expected_rsp.push_back(r);
      end
      if (ended) begin
         r = '0;
         r.stream_end = 1;
         r.last_result = 1;
         expected_rsp.push_back(r);
      end
   endfunction

   // Channel monitor: predict on each request transfer, compare each result transfer.
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         restart_stream();
         expected_rsp.delete();
         fail_count = 0;
         for (int i = 0; i < WINDOW_DEPTH; i++) hist[i] = '0;
      end else begin
         if (req_valid && req_ready) decode_byte(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: result with nothing expected: %h", $time, rsp_data);
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data.out_bytes !== e.out_bytes)
                  $display("%0t: out_bytes expected %h actual %h",
                           $time, e.out_bytes, rsp_data.out_bytes);
               if (rsp_data.byte_count !== e.byte_count)
                  $display("%0t: byte_count expected %0d actual %0d",
                           $time, e.byte_count, rsp_data.byte_count);
               if (rsp_data.stream_end !== e.stream_end)
                  $display("%0t: stream_end expected %b actual %b",
                           $time, e.stream_end, rsp_data.stream_end);
               if (rsp_data.last_result !== e.last_result)
                  $display("%0t: last_result expected %b actual %b",
                           $time, e.last_result, rsp_data.last_result);
               if (rsp_data !== e) fail_count++;
            end
         end
      end
      pending = expected_rsp.size();
   end

endmodule

`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives compressed streams into the LZ bit-flag decompressor: a directed
// stream, one stream grown past the full window, then random streams, some
// cut short. Results are checked by lzbf_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import lzbf_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int ITEM_TARGET = 380;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;

   int      cycles = 0;
   int      accepted = 0;
   int      items_sent = 0;
   bit      calm = 0;
   bit      hold = 0;
   int      burst = 0;

   // Stream under construction.
   logic [7:0] stream_bytes [$];
   int         flag_pos;
   int         flag_used;
   int         out_len;

   lz_bitflag_decompressor uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   lzbf_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Count request transfers so the sender can see them at the falling edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) accepted <= accepted + 1;
   end

   // Receiver: random stall bursts, plus the long hold-off.
   always @(negedge clock) begin
      if (burst > 0) begin
         burst <= burst - 1;
         rsp_ready <= 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         burst <= $urandom_range(0, 5);
         rsp_ready <= 0;
      end else begin
         rsp_ready <= !hold;
      end
   end

   // Long receiver hold-off while the sender keeps offering bytes.
   initial begin
      wait (items_sent >= 150);
      @(posedge clock);
      hold = 1;
      repeat (400) @(posedge clock);
      hold = 0;
   end

   // Stream encoder. A flag word is reserved in the stream when a control bit
   // is needed and the previous word is used up, as the decoder expects.
   function automatic void put_flag(input bit v);
      if (flag_used == 16) begin
         flag_pos = stream_bytes.size();
         stream_bytes.push_back(8'h00);
         stream_bytes.push_back(8'h00);
         flag_used = 0;
      end
      if (v) stream_bytes[flag_pos + flag_used / 8] =
             stream_bytes[flag_pos + flag_used / 8] | (8'd1 << (flag_used % 8));
      flag_used++;
   endfunction

   function automatic void tok_literal(input logic [7:0] v);
      put_flag(1);
      stream_bytes.push_back(v);
      out_len++;
   endfunction

   function automatic void tok_near(input int ofs);
      put_flag(0); put_flag(0); put_flag(0);
      stream_bytes.push_back(ofs - 1);
      out_len += 2;
   endfunction

   function automatic void tok_end();
      put_flag(0); put_flag(0); put_flag(0);
      stream_bytes.push_back(END_BYTE);
   endfunction

   function automatic void tok_far(input int ofs);
      logic [10:0] d;
      d = ofs - 256;
      put_flag(0); put_flag(0); put_flag(1);
      put_flag(d[10]); put_flag(d[9]); put_flag(d[8]);
      stream_bytes.push_back(d[7:0]);
      out_len += 2;
   endfunction

   // Long match: offset prefix class, offset byte, then the length code.
   function automatic void tok_long(input int ofs, input int len);
      logic [11:0] d;
      logic [7:0]  lb;
      put_flag(0); put_flag(1);
      if (ofs <= 512) begin
         d = ofs - 1;
         put_flag(d[8]); put_flag(1);
      end else if (ofs <= 1024) begin
         d = ofs - 513;
         put_flag(d[8]); put_flag(0); put_flag(1);
      end else if (ofs <= 2048) begin
         d = ofs - 1025;
         put_flag(d[9]); put_flag(0); put_flag(0); put_flag(d[8]); put_flag(1);
      end else if (ofs <= 4096) begin
         d = ofs - 2049;
         put_flag(d[10]); put_flag(0); put_flag(0); put_flag(d[9]); put_flag(0);
         put_flag(d[8]); put_flag(1);
      end else begin
         d = ofs - 4097;
         put_flag(d[11]); put_flag(0); put_flag(0); put_flag(d[10]); put_flag(0);
         put_flag(d[9]); put_flag(0); put_flag(d[8]);
      end
      stream_bytes.push_back(d[7:0]);
      if (len <= 6) begin
         repeat (len - 3) put_flag(0);
         put_flag(1);
      end else begin
         repeat (4) put_flag(0);
         if (len <= 8) begin
            put_flag(1);
            put_flag(len == 8);
         end else if (len >= 17) begin
            put_flag(0); put_flag(1);
            lb = len - 17;
            stream_bytes.push_back(lb);
         end else begin
            lb = len - 9;
            put_flag(0); put_flag(0);
            put_flag(lb[2]); put_flag(lb[1]); put_flag(lb[0]);
         end
      end
      out_len += len;
   endfunction

   function automatic void open_stream();
      stream_bytes.delete();
      flag_used = 16;
      flag_pos = 0;
      out_len = 0;
   endfunction

   // Value in lo..hi, leaning toward both ends.
   function automatic int pick(input int lo, input int hi);
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   function automatic int pick_length();
      case ($urandom_range(0, 7))
         6: return $urandom_range(9, 16);
         7: return pick(17, 272);
         default: return $urandom_range(3, 8);
      endcase
   endfunction

   // One random token that only reaches back into bytes of this stream.
   function automatic void random_token(input bit grow);
      int lim;
      lim = (out_len < 8192) ? out_len : 8192;
      if (grow) begin
         tok_long(pick(1, lim), 272);
         return;
      end
      case ($urandom_range(0, 9))
         0, 1, 2: tok_literal($urandom_range(0, 255));
         3: tok_near(pick(1, (lim < 255) ? lim : 255));
         4: begin
            if (lim >= 256) tok_far(pick(256, (lim < 2303) ? lim : 2303));
            else tok_literal($urandom_range(0, 255));
         end
         default: tok_long(pick(1, lim), pick_length());
      endcase
   endfunction

   // One transfer on the request channel, with an optional gap before it.
   task automatic send_byte(input logic [7:0] b, input bit ns);
      int seen;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{in_byte: b, new_stream: ns};
      seen = accepted;
      do @(negedge clock); while (accepted == seen);
   endtask

   task automatic send_stream(input int upto);
      for (int i = 0; i < upto; i++) begin
         send_byte(stream_bytes[i], i == 0);
         items_sent++;
         if (items_sent > ITEM_TARGET - 50) calm = 1;
      end
   endtask

   // Bytes after an end marker are ignored by the block.
   task automatic send_ignored(input int n);
      repeat (n) send_byte($urandom_range(0, 255), 0);
   endtask

   initial begin
      int ntok;
      repeat (3) @(negedge clock);
      reset <= 0;

      // Directed stream: literal extremes, overlapping copies, length codes.
      open_stream();
      tok_literal(8'h00);
      tok_literal(8'hff);
      tok_literal(8'ha5);
      tok_near(1);
      tok_long(3, 272);
      tok_long(1, 9);
      tok_long(255, 16);
      tok_near(255);
      tok_long(277, 7);
      tok_end();
      send_stream(stream_bytes.size());
      send_ignored(2);

      // A stream that fills the whole window, then reaches its far end.
      open_stream();
      tok_literal($urandom_range(0, 255));
      while (out_len < 8300) random_token(1);
      tok_long(8192, 3);
      tok_long(4097, 8);
      tok_long(4096, 17);
      tok_long(2049, 5);
      tok_long(2048, 6);
      tok_long(1025, 4);
      tok_long(1024, 3);
      tok_long(513, 3);
      tok_long(512, 3);
      tok_far(2303);
      tok_far(256);
      tok_end();
      send_stream(stream_bytes.size());

      // Random streams; some are cut off and abandoned by the next stream.
      while (items_sent < ITEM_TARGET) begin
         open_stream();
         tok_literal($urandom_range(0, 255));
         ntok = $urandom_range(3, 16);
         repeat (ntok) random_token(0);
         tok_end();
         if ($urandom_range(0, 5) == 0) begin
            send_stream($urandom_range(1, stream_bytes.size() - 1));
         end else begin
            send_stream(stream_bytes.size());
            send_ignored($urandom_range(0, 2));
         end
      end
      req_valid <= 0;

      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
